// ===== sv/mlfq_pkg.sv =====
// Package for the three-level feedback queue scheduler.
// Types, constants and status codes shared by controller, datapath and top.
`timescale 1ns / 1ps
`default_nettype none
package mlfq_pkg;
  localparam int MaxTasks = 64;
  localparam int SlotW = $clog2(MaxTasks);
  localparam int CntW = SlotW + 1;
  localparam int QAddrW = SlotW + 2;
  localparam logic [24:0] Sat25 = 25'h1FFFFFF;

  localparam logic [1:0] QLow = 2'd0;
  localparam logic [1:0] QMed = 2'd1;
  localparam logic [1:0] QHigh = 2'd2;
  localparam logic [1:0] QReady = 2'd3;

  localparam logic [1:0] RegQuantum = 2'd0;
  localparam logic [1:0] RegAllot = 2'd1;
  localparam logic [1:0] RegBoost = 2'd2;

  localparam logic [2:0] StAdded = 3'd0;
  localparam logic [2:0] StRan = 3'd1;
  localparam logic [2:0] StFinished = 3'd2;
  localparam logic [2:0] StDemoted = 3'd3;
  localparam logic [2:0] StIoYield = 3'd4;
  localparam logic [2:0] StIdle = 3'd5;
  localparam logic [2:0] StAllDone = 3'd6;
  localparam logic [2:0] StFull = 3'd7;

  typedef struct packed {
    logic op;
    logic [23:0] job_length;
    logic [6:0] io_odds;
    logic [6:0] io_roll;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] task_index;
    logic [15:0] run_time;
    logic [1:0] level;
    logic boosted;
  } out_beat_t;

  typedef enum logic [2:0] {
    CmdNone, CmdAdd, CmdBoostStart, CmdBoostRead, CmdBoostMove, CmdSelect, CmdRead,
    CmdDecide
  } cmd_t;

  typedef struct packed {
    logic full;
    logic boost_due;
    logic boost_busy;
    logic pick_none;
  } stat_t;
endpackage
`default_nettype wire

// ===== sv/mlfq_task_scheduler_unit.sv =====
// Top level of the three-level feedback queue scheduler.
// Depends on mlfq_pkg, mlfq_ctrl and mlfq_datapath.
`timescale 1ns / 1ps
`default_nettype none
// One beat in, one beat out. An add is answered straight from idle; a step runs through
// boost check, select, queue read, table read and decide, and stops after the queue read
// when it ends idle or all done. A due boost adds a final boost check plus a read and a
// move for each task moved from the medium and low queues. The next beat is accepted only
// when no result is pending or in the cycle the pending result is taken.
module mlfq_task_scheduler_unit (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire mlfq_pkg::in_beat_t in_data,
  output logic out_valid,
  input wire logic out_stall,
  output mlfq_pkg::out_beat_t out_data,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [23:0] cfg_data
);
  logic [15:0] quantum_length;
  logic [23:0] allotment_limit;
  logic [23:0] boost_threshold;
  mlfq_pkg::in_beat_t item;
  mlfq_pkg::cmd_t cmd;
  mlfq_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_length <= 16'd50;
      allotment_limit <= 24'd200;
      boost_threshold <= 24'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        mlfq_pkg::RegQuantum: quantum_length <= cfg_data[15:0];
        mlfq_pkg::RegAllot: allotment_limit <= cfg_data;
        mlfq_pkg::RegBoost: boost_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  mlfq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_op(in_data.op),
    .out_stall(out_stall), .stat(stat),
    .in_stall(in_stall), .out_valid(out_valid), .cmd(cmd)
  );

  mlfq_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .item((cmd == mlfq_pkg::CmdAdd) ? in_data : item),
    .quantum_length(quantum_length), .allotment_limit(allotment_limit),
    .boost_threshold(boost_threshold), .stat(stat), .result(out_data)
  );

`ifndef SYNTHESIS
  a_in_block: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall) else $error("beat accepted over held result");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// ===== sv/mlfq_datapath.sv =====
// Datapath of the scheduler: task tables, queue memory, queue pointers.
// Depends on mlfq_pkg; driven by commands from mlfq_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_datapath (
  input wire logic clk,
  input wire logic rst,
  input wire mlfq_pkg::cmd_t cmd,
  input wire mlfq_pkg::in_beat_t item,
  input wire logic [15:0] quantum_length,
  input wire logic [23:0] allotment_limit,
  input wire logic [23:0] boost_threshold,
  output mlfq_pkg::stat_t stat,
  output mlfq_pkg::out_beat_t result
);
  logic [23:0] remaining_time [mlfq_pkg::MaxTasks];
  logic [24:0] used_allotment [mlfq_pkg::MaxTasks];
  logic [1:0] task_level [mlfq_pkg::MaxTasks];
  logic [6:0] task_odds [mlfq_pkg::MaxTasks];
  logic [mlfq_pkg::SlotW-1:0] queue_slots [4*mlfq_pkg::MaxTasks];

  logic [mlfq_pkg::SlotW-1:0] heads [4];
  logic [mlfq_pkg::CntW-1:0] counts [4];
  logic [24:0] elapsed_total;
  logic [mlfq_pkg::CntW-1:0] tasks_added;
  logic [mlfq_pkg::CntW-1:0] tasks_finished;
  logic boosted;
  logic [1:0] pick_q;
  logic [mlfq_pkg::SlotW-1:0] rd_slot;
  logic [mlfq_pkg::SlotW-1:0] slot;
  logic [23:0] t_rem;
  logic [24:0] t_used;
  logic [1:0] t_lvl;
  logic [6:0] t_odds;
  logic [1:0] boost_q;
  logic [1:0] boost_pick;
  logic [1:0] rd_q;

  logic push_en;
  logic [1:0] push_q;
  logic [mlfq_pkg::SlotW-1:0] push_slot;
  logic [mlfq_pkg::SlotW-1:0] push_pos;
  logic [24:0] used_sum;
  logic [24:0] el_sum;
  logic [23:0] run24;
  logic [1:0] lvl_dec;

  assign stat.full = tasks_added == mlfq_pkg::CntW'(mlfq_pkg::MaxTasks);
  assign stat.boost_due = elapsed_total >= {1'b0, boost_threshold};
  assign stat.boost_busy = (counts[mlfq_pkg::QMed] != '0) || (counts[mlfq_pkg::QLow] != '0);
  assign stat.pick_none = (counts[mlfq_pkg::QReady] == '0 && tasks_finished == tasks_added) ||
                          (counts[pick_q] == '0);
  assign lvl_dec = t_lvl - 2'd1;
  assign boost_pick = (counts[mlfq_pkg::QMed] != '0) ? mlfq_pkg::QMed : mlfq_pkg::QLow;
  assign rd_q = (cmd == mlfq_pkg::CmdBoostRead) ? boost_pick : pick_q;

  always_comb begin
    run24 = (t_rem <= {8'd0, quantum_length}) ? t_rem : {8'd0, quantum_length};
    used_sum = (26'(t_used) + 26'(run24) > 26'(mlfq_pkg::Sat25)) ? mlfq_pkg::Sat25 :
               t_used + 25'(run24);
    el_sum = (26'(elapsed_total) + 26'(run24) > 26'(mlfq_pkg::Sat25)) ? mlfq_pkg::Sat25 :
             elapsed_total + 25'(run24);
    push_en = 1'b0;
    push_q = mlfq_pkg::QReady;
    push_slot = slot;
    case (cmd)
      mlfq_pkg::CmdAdd: begin
        push_en = !stat.full && !item.op;
        push_slot = tasks_added[mlfq_pkg::SlotW-1:0];
      end
      mlfq_pkg::CmdDecide: begin
        push_en = !(item.io_roll > t_odds) ? 1'b1 :
                  (t_used >= {1'b0, allotment_limit} && t_lvl != mlfq_pkg::QLow) ? 1'b1 :
                  !(t_rem <= {8'd0, quantum_length});
        push_q = (!(item.io_roll > t_odds)) ? t_lvl :
                 (t_used >= {1'b0, allotment_limit} && t_lvl != mlfq_pkg::QLow) ? lvl_dec :
                 t_lvl;
      end
      mlfq_pkg::CmdBoostMove: begin
        push_en = 1'b1;
        push_q = mlfq_pkg::QHigh;
        push_slot = rd_slot;
      end
      default: ;
    endcase
    push_pos = heads[push_q] + counts[push_q][mlfq_pkg::SlotW-1:0];
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      queue_slots[{push_q, push_pos}] <= push_slot;
    end
    rd_slot <= queue_slots[{rd_q, heads[rd_q]}];
    t_rem <= remaining_time[rd_slot];
    t_used <= used_allotment[rd_slot];
    t_lvl <= task_level[rd_slot];
    t_odds <= task_odds[rd_slot];
    slot <= rd_slot;
    if (cmd == mlfq_pkg::CmdAdd && !stat.full) begin
      remaining_time[tasks_added[mlfq_pkg::SlotW-1:0]] <= item.job_length;
      task_odds[tasks_added[mlfq_pkg::SlotW-1:0]] <= item.io_odds;
      used_allotment[tasks_added[mlfq_pkg::SlotW-1:0]] <= '0;
      task_level[tasks_added[mlfq_pkg::SlotW-1:0]] <= mlfq_pkg::QHigh;
    end
    if (cmd == mlfq_pkg::CmdBoostMove) begin
      used_allotment[rd_slot] <= '0;
      task_level[rd_slot] <= mlfq_pkg::QHigh;
    end
    if (cmd == mlfq_pkg::CmdDecide && item.io_roll > t_odds) begin
      if (t_used >= {1'b0, allotment_limit} && t_lvl != mlfq_pkg::QLow) begin
        task_level[slot] <= lvl_dec;
        used_allotment[slot] <= '0;
      end else begin
        remaining_time[slot] <= t_rem - run24;
        used_allotment[slot] <= used_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        heads[i] <= '0;
        counts[i] <= '0;
      end
      elapsed_total <= '0;
      tasks_added <= '0;
      tasks_finished <= '0;
      boosted <= 1'b0;
      pick_q <= mlfq_pkg::QReady;
      boost_q <= mlfq_pkg::QMed;
    end else begin
      case (cmd)
        mlfq_pkg::CmdAdd: begin
          if (!stat.full) begin
            tasks_added <= tasks_added + 1'b1;
            counts[mlfq_pkg::QReady] <= counts[mlfq_pkg::QReady] + 1'b1;
            result <= '{mlfq_pkg::StAdded, 6'(tasks_added[mlfq_pkg::SlotW-1:0]),
                        16'd0, mlfq_pkg::QHigh, 1'b0};
          end else begin
            result <= '{mlfq_pkg::StFull, 6'd0, 16'd0, 2'd0, 1'b0};
          end
        end
        mlfq_pkg::CmdBoostStart: begin
          boosted <= stat.boost_due;
          if (stat.boost_due) begin
            elapsed_total <= '0;
          end
        end
        mlfq_pkg::CmdBoostRead: begin
          boost_q <= boost_pick;
        end
        mlfq_pkg::CmdBoostMove: begin
          heads[boost_q] <= heads[boost_q] + 1'b1;
          counts[boost_q] <= counts[boost_q] - 1'b1;
          counts[mlfq_pkg::QHigh] <= counts[mlfq_pkg::QHigh] + 1'b1;
        end
        mlfq_pkg::CmdSelect: begin
          if (counts[mlfq_pkg::QReady] != '0) begin
            pick_q <= mlfq_pkg::QReady;
          end else if (counts[mlfq_pkg::QHigh] != '0) begin
            pick_q <= mlfq_pkg::QHigh;
          end else if (counts[mlfq_pkg::QMed] != '0) begin
            pick_q <= mlfq_pkg::QMed;
          end else begin
            pick_q <= mlfq_pkg::QLow;
          end
        end
        mlfq_pkg::CmdRead: begin
          if (counts[mlfq_pkg::QReady] == '0 && tasks_finished == tasks_added) begin
            result <= '{mlfq_pkg::StAllDone, 6'd0, 16'd0, 2'd0, boosted};
            pick_q <= mlfq_pkg::QReady;
          end else if (counts[pick_q] == '0) begin
            result <= '{mlfq_pkg::StIdle, 6'd0, 16'd0, 2'd0, boosted};
            pick_q <= mlfq_pkg::QReady;
          end else begin
            heads[pick_q] <= heads[pick_q] + 1'b1;
            counts[pick_q] <= counts[pick_q] - 1'b1;
          end
        end
        mlfq_pkg::CmdDecide: begin
          if (push_en) begin
            counts[push_q] <= counts[push_q] + 1'b1;
          end
          if (!(item.io_roll > t_odds)) begin
            result <= '{mlfq_pkg::StIoYield, 6'(slot), 16'd0, t_lvl, boosted};
          end else if (t_used >= {1'b0, allotment_limit} && t_lvl != mlfq_pkg::QLow) begin
            result <= '{mlfq_pkg::StDemoted, 6'(slot), 16'd0, lvl_dec, boosted};
          end else begin
            elapsed_total <= el_sum;
            if (t_rem <= {8'd0, quantum_length}) begin
              tasks_finished <= tasks_finished + 1'b1;
              result <= '{mlfq_pkg::StFinished, 6'(slot), run24[15:0], t_lvl, boosted};
            end else begin
              result <= '{mlfq_pkg::StRan, 6'(slot), quantum_length, t_lvl, boosted};
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/mlfq_ctrl.sv =====
// Controller of the scheduler: sequences one beat through the datapath.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_ctrl (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_op,
  input wire logic out_stall,
  input wire mlfq_pkg::stat_t stat,
  output logic in_stall,
  output logic out_valid,
  output mlfq_pkg::cmd_t cmd
);
  typedef enum logic [2:0] {
    SIdle, SBoost, SMove, SSel, SRead, SWait, SDec, SOut
  } state_t;
  state_t state;

  logic out_set;
  assign in_stall = (state != SIdle) || (out_valid && out_stall);
  assign out_set = (state == SIdle && cmd == mlfq_pkg::CmdAdd) ||
                   (state == SRead && stat.pick_none) || (state == SDec);

  always_comb begin
    case (state)
      SIdle: cmd = (in_valid && !in_stall) ?
                   (in_op ? mlfq_pkg::CmdBoostStart : mlfq_pkg::CmdAdd) : mlfq_pkg::CmdNone;
      SBoost: cmd = stat.boost_busy ? mlfq_pkg::CmdBoostRead : mlfq_pkg::CmdNone;
      SMove: cmd = mlfq_pkg::CmdBoostMove;
      SSel: cmd = mlfq_pkg::CmdSelect;
      SRead: cmd = mlfq_pkg::CmdRead;
      SDec: cmd = mlfq_pkg::CmdDecide;
      default: cmd = mlfq_pkg::CmdNone;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_set || (out_valid && out_stall);
      case (state)
        SIdle: begin
          if (cmd == mlfq_pkg::CmdBoostStart) begin
            state <= stat.boost_due ? SBoost : SSel;
          end
        end
        SBoost: state <= stat.boost_busy ? SMove : SSel;
        SMove: state <= SBoost;
        SSel: state <= SRead;
        SRead: state <= stat.pick_none ? SIdle : SWait;
        SWait: state <= SDec;
        SDec: state <= SIdle;
        default: state <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_mlfq_task_scheduler_unit.sv =====
// Testbench for mlfq_task_scheduler_unit: directed table then random adds/steps, checked beat
// by beat against fixed expectations or an in-bench scheduler predictor. Depends on mlfq_pkg.
`timescale 1ns / 1ps
module tb_mlfq_task_scheduler_unit;
  localparam int WdogLimit = 3000;
  localparam int HoldCycles = 300;

  typedef struct {
    mlfq_pkg::in_beat_t beat;
    bit known;
    mlfq_pkg::out_beat_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  mlfq_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  mlfq_pkg::out_beat_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [23:0] cfg_data;

  // scheduler state mirror
  logic [15:0] quantum;
  logic [23:0] allot_lim;
  logic [23:0] boost_thr;
  logic [23:0] rem_time[mlfq_pkg::MaxTasks];
  logic [24:0] used_time[mlfq_pkg::MaxTasks];
  logic [1:0] task_lvl[mlfq_pkg::MaxTasks];
  logic [6:0] task_odds[mlfq_pkg::MaxTasks];
  int level_fifo[4][$];
  logic [24:0] elapsed;
  int n_added;
  int n_done;

  mlfq_pkg::out_beat_t sched_results[$];
  stim_row_t dir_rows[$];
  int errors;
  bit hold_req;
  int add_pct;

  mlfq_task_scheduler_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [24:0] sat_sum(logic [24:0] a, logic [24:0] b);
    logic [25:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s > {1'b0, mlfq_pkg::Sat25} ? mlfq_pkg::Sat25 : s[24:0];
  endfunction

  function automatic mlfq_pkg::out_beat_t schedule(mlfq_pkg::in_beat_t b);
    mlfq_pkg::out_beat_t r;
    int slot;
    logic [1:0] lv;
    logic [23:0] run;
    r = '0;
    if (!b.op) begin
      if (n_added >= mlfq_pkg::MaxTasks) begin
        r.status = mlfq_pkg::StFull;
        return r;
      end
      slot = n_added;
      rem_time[slot] = b.job_length;
      task_odds[slot] = b.io_odds;
      used_time[slot] = '0;
      task_lvl[slot] = mlfq_pkg::QHigh;
      level_fifo[mlfq_pkg::QReady].push_back(slot);
      n_added++;
      r.status = mlfq_pkg::StAdded;
      r.task_index = slot[5:0];
      r.level = mlfq_pkg::QHigh;
      return r;
    end
    if (elapsed >= {1'b0, boost_thr}) begin
      for (int q = int'(mlfq_pkg::QMed); q >= int'(mlfq_pkg::QLow); q--) begin
        while (level_fifo[q].size() != 0) begin
          slot = level_fifo[q].pop_front();
          task_lvl[slot] = mlfq_pkg::QHigh;
          used_time[slot] = '0;
          level_fifo[mlfq_pkg::QHigh].push_back(slot);
        end
      end
      elapsed = '0;
      r.boosted = 1'b1;
    end
    if (level_fifo[mlfq_pkg::QReady].size() != 0) begin
      slot = level_fifo[mlfq_pkg::QReady].pop_front();
    end else if (n_done == n_added) begin
      r.status = mlfq_pkg::StAllDone;
      return r;
    end else if (level_fifo[mlfq_pkg::QHigh].size() != 0) begin
      slot = level_fifo[mlfq_pkg::QHigh].pop_front();
    end else if (level_fifo[mlfq_pkg::QMed].size() != 0) begin
      slot = level_fifo[mlfq_pkg::QMed].pop_front();
    end else if (level_fifo[mlfq_pkg::QLow].size() != 0) begin
      slot = level_fifo[mlfq_pkg::QLow].pop_front();
    end else begin
      r.status = mlfq_pkg::StIdle;
      return r;
    end
    lv = task_lvl[slot];
    r.task_index = slot[5:0];
    if (b.io_roll <= task_odds[slot]) begin
      level_fifo[lv].push_back(slot);
      r.status = mlfq_pkg::StIoYield;
      r.level = lv;
      return r;
    end
    if (used_time[slot] >= {1'b0, allot_lim} && lv != mlfq_pkg::QLow) begin
      lv = lv - 2'd1;
      task_lvl[slot] = lv;
      used_time[slot] = '0;
      level_fifo[lv].push_back(slot);
      r.status = mlfq_pkg::StDemoted;
      r.level = lv;
      return r;
    end
    if (rem_time[slot] <= {8'd0, quantum}) begin
      run = rem_time[slot];
      rem_time[slot] = '0;
      n_done++;
      r.status = mlfq_pkg::StFinished;
    end else begin
      run = {8'd0, quantum};
      rem_time[slot] = rem_time[slot] - run;
      level_fifo[lv].push_back(slot);
      r.status = mlfq_pkg::StRan;
    end
    used_time[slot] = sat_sum(used_time[slot], {1'b0, run});
    elapsed = sat_sum(elapsed, {1'b0, run});
    r.run_time = run[15:0];
    r.level = lv;
    return r;
  endfunction

  task automatic push_row(logic op, logic [23:0] len, logic [6:0] odds, logic [6:0] roll,
                          bit known, logic [2:0] st, logic [5:0] idx, logic [1:0] lvl);
    stim_row_t row;
    row.beat = '{op: op, job_length: len, io_odds: odds, io_roll: roll};
    row.known = known;
    row.want = '{status: st, task_index: idx, run_time: 16'd0, level: lvl, boosted: 1'b0};
    dir_rows.push_back(row);
  endtask

  function automatic mlfq_pkg::in_beat_t rand_beat();
    mlfq_pkg::in_beat_t b;
    int pick;
    b.op = ($urandom_range(0, 99) < add_pct) ? 1'b0 : 1'b1;
    pick = $urandom_range(0, 9);
    if (pick < 6) b.job_length = 24'($urandom_range(0, 300));
    else if (pick < 9) b.job_length = 24'($urandom_range(0, 3000));
    else b.job_length = 24'($urandom_range(0, 24'hFFFFFF));
    b.io_odds = 7'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) :
                   $urandom_range(0, 20));
    b.io_roll = 7'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) :
                   $urandom_range(0, 100));
    return b;
  endfunction

  task automatic write_cfg(logic [15:0] q, logic [23:0] a, logic [23:0] t);
    cfg_we <= 1'b1;
    cfg_index <= mlfq_pkg::RegQuantum;
    cfg_data <= {8'd0, q};
    @(posedge clk);
    cfg_index <= mlfq_pkg::RegAllot;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= mlfq_pkg::RegBoost;
    cfg_data <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    quantum = q;
    allot_lim = a;
    boost_thr = t;
  endtask

  task automatic send_beat(mlfq_pkg::in_beat_t b, bit known, mlfq_pkg::out_beat_t want);
    int gap;
    mlfq_pkg::out_beat_t pred;
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = schedule(b);
    sched_results.push_back(known ? want : pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sched_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // receiver: random stall per beat, plus one long hold on request
  initial begin
    int stall_left;
    mlfq_pkg::out_beat_t want;
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (sched_results.size() == 0) begin
          $error("unexpected beat status=%0d", out_data.status);
          errors++;
        end else begin
          want = sched_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status exp=%0d got=%0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.task_index !== want.task_index) begin
            $error("task_index exp=%0d got=%0d", want.task_index, out_data.task_index);
            errors++;
          end
          if (out_data.run_time !== want.run_time) begin
            $error("run_time exp=%0d got=%0d", want.run_time, out_data.run_time);
            errors++;
          end
          if (out_data.level !== want.level) begin
            $error("level exp=%0d got=%0d", want.level, out_data.level);
            errors++;
          end
          if (out_data.boosted !== want.boosted) begin
            $error("boosted exp=%0d got=%0d", want.boosted, out_data.boosted);
            errors++;
          end
        end
        stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      end
      if (hold_req) begin
        stall_left = HoldCycles;
        hold_req = 1'b0;
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    mlfq_pkg::out_beat_t none;
    logic [15:0] qs[4];
    logic [23:0] as[4];
    logic [23:0] ts[4];
    none = '0;
    errors = 0;
    hold_req = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = mlfq_pkg::RegQuantum;
    cfg_data = '0;
    quantum = 16'd50;
    allot_lim = 24'd200;
    boost_thr = 24'd1000;
    elapsed = '0;
    n_added = 0;
    n_done = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_row(1'b1, 24'd0, 7'd0, 7'd0, 1, mlfq_pkg::StAllDone, 6'd0, mlfq_pkg::QLow);
    push_row(1'b0, 24'd0, 7'd0, 7'd0, 1, mlfq_pkg::StAdded, 6'd0, mlfq_pkg::QHigh);
    push_row(1'b1, 24'd0, 7'd0, 7'd1, 1, mlfq_pkg::StFinished, 6'd0, mlfq_pkg::QHigh);
    push_row(1'b0, 24'hFFFFFF, 7'd127, 7'd0, 1, mlfq_pkg::StAdded, 6'd1, mlfq_pkg::QHigh);
    push_row(1'b1, 24'd0, 7'd0, 7'd127, 1, mlfq_pkg::StIoYield, 6'd1, mlfq_pkg::QHigh);
    push_row(1'b0, 24'd120, 7'd0, 7'd0, 0, 3'd0, 6'd0, 2'd0);
    push_row(1'b0, 24'd50, 7'd100, 7'd0, 0, 3'd0, 6'd0, 2'd0);
    push_row(1'b0, 24'd1000, 7'd0, 7'd0, 0, 3'd0, 6'd0, 2'd0);
    for (int i = 0; i < 16; i++)
      push_row(1'b1, 24'd0, 7'd0, (i % 2) ? 7'd101 : 7'd127, 0, 3'd0, 6'd0, 2'd0);
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].known, dir_rows[i].want);
    drain();

    qs = '{16'd1, 16'd65535, 16'd7, 16'd40};
    as = '{24'd0, 24'hFFFFFF, 24'd30, 24'd120};
    ts = '{24'd1, 24'hFFFFFF, 24'd100, 24'd600};
    for (int p = 0; p < 4; p++) begin
      write_cfg(qs[p], as[p], ts[p]);
      add_pct = (p == 0) ? 25 : 12;
      for (int i = 0; i < 150; i++) begin
        if (p == 1 && i == 40) hold_req = 1'b1;
        send_beat(rand_beat(), 0, none);
      end
      drain();
    end

    if (errors == 0 && sched_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
